// File: sv/vcso_pkg.sv
// ----------------------------------------------------------------------------
// vcso_pkg
// Shared types, register indexes and helpers of the column span occluder.
// ----------------------------------------------------------------------------
`default_nettype none

package vcso_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;
	localparam int DIV_W = 30;
	localparam int DIVISOR_W = 10;
	localparam int ROW_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_ALTITUDE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZON = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HSCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SKY_RED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SKY_GREEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SKY_BLUE = 3'd5;

	localparam logic [19:0] ALTITUDE_RST = 20'd65536;
	localparam logic signed [17:0] HORIZON_RST = 18'sd25600;
	localparam logic [9:0] HSCALE_RST = 10'd256;
	localparam logic [7:0] SKY_RED_RST = 8'd135;
	localparam logic [7:0] SKY_GREEN_RST = 8'd206;
	localparam logic [7:0] SKY_BLUE_RST = 8'd235;

	typedef struct packed {
		logic mode;
		logic [9:0] column;
		logic [2:0] cover_cols;
		logic [9:0] distance;
		logic [7:0] terrain_height;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [8:0] fog_alpha;
	} in_item_t;

	typedef struct packed {
		logic [9:0] span_x;
		logic [8:0] span_top;
		logic [2:0] span_width;
		logic [8:0] span_height;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic clr_init;
		logic clr_step;
		logic rd_step;
		logic row_calc;
		logic k_clr;
		logic wr_step;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_mode;
		logic in_col_ok;
		logic clr_last;
		logic k_last;
		logic div_busy;
		logic visible;
		logic out_free;
	} ctl_sts_t;

	function automatic logic [7:0] fog_mix(logic [7:0] c, logic [7:0] sky, logic [8:0] a);
		logic [8:0] inv;
		logic [16:0] t;
		inv = 9'd256 - a;
		t = 17'(c * inv) + 17'(sky * a);
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

// File: sv/vcso_ctrl.sv
// ----------------------------------------------------------------------------
// vcso_ctrl
// Sequencer: buffer clear, span read, divide wait, visibility, write, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module vcso_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire vcso_pkg::ctl_sts_t sts,
	output vcso_pkg::ctl_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_READ  = 8'b0000_0100,
		S_DIV   = 8'b0000_1000,
		S_ROW   = 8'b0001_0000,
		S_CHECK = 8'b0010_0000,
		S_WRITE = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!sts.in_mode) begin
						cmd.clr_init = 1'b1;
						state_d = S_CLEAR;
					end else if (sts.in_col_ok) begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.rd_step = 1'b1;
				if (sts.k_last) state_d = S_DIV;
			end
			S_DIV: begin
				if (!sts.div_busy) state_d = S_ROW;
			end
			S_ROW: begin
				cmd.row_calc = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.k_clr = 1'b1;
				state_d = sts.visible ? S_WRITE : S_IDLE;
			end
			S_WRITE: begin
				cmd.wr_step = 1'b1;
				if (sts.k_last) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

`default_nettype wire

// File: sv/vcso_dpath.sv
// ----------------------------------------------------------------------------
// vcso_dpath
// Registers, occlusion buffer, serial divider, projection and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vcso_dpath #(
	parameter int SCREEN_WIDTH = 640,
	parameter int SCREEN_HEIGHT = 360,
	parameter int MAX_FILL = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [vcso_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vcso_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire vcso_pkg::in_item_t in_data,
	input  wire logic out_ready,
	output logic out_valid,
	output vcso_pkg::out_item_t out_data,
	input  wire vcso_pkg::ctl_cmd_t cmd,
	output vcso_pkg::ctl_sts_t sts
);

	localparam int AW = (SCREEN_WIDTH > 2) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int HW = $clog2(SCREEN_HEIGHT + 1);
	localparam int FWW = $clog2(MAX_FILL + 1);
	localparam int XW = $clog2(SCREEN_WIDTH + 1024 + 16);
	localparam int RW = vcso_pkg::ROW_W;
	localparam int DW = vcso_pkg::DIV_W;
	localparam int VW = vcso_pkg::DIVISOR_W;
	localparam int CW = $clog2(DW + 1);

	// configuration
	logic [19:0] alt_q;
	logic signed [17:0] hor_q;
	logic [9:0] scl_q;
	logic [7:0] sky_r_q, sky_g_q, sky_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q <= vcso_pkg::ALTITUDE_RST;
			hor_q <= vcso_pkg::HORIZON_RST;
			scl_q <= vcso_pkg::HSCALE_RST;
			sky_r_q <= vcso_pkg::SKY_RED_RST;
			sky_g_q <= vcso_pkg::SKY_GREEN_RST;
			sky_b_q <= vcso_pkg::SKY_BLUE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vcso_pkg::REG_ALTITUDE: alt_q <= cfg_data[19:0];
				vcso_pkg::REG_HORIZON: hor_q <= $signed(cfg_data[17:0]);
				vcso_pkg::REG_HSCALE: scl_q <= cfg_data[9:0];
				vcso_pkg::REG_SKY_RED: sky_r_q <= cfg_data[7:0];
				vcso_pkg::REG_SKY_GREEN: sky_g_q <= cfg_data[7:0];
				vcso_pkg::REG_SKY_BLUE: sky_b_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// item decode
	logic [FWW-1:0] fw_n;
	logic col_ok;
	always_comb begin
		int fw_i;
		fw_i = int'(in_data.cover_cols);
		if (fw_i == 0) fw_i = 1;
		if (fw_i > MAX_FILL) fw_i = MAX_FILL;
		if (int'(in_data.column) + fw_i > SCREEN_WIDTH) fw_i = SCREEN_WIDTH - int'(in_data.column);
		fw_n = FWW'(fw_i);
		col_ok = int'(in_data.column) < SCREEN_WIDTH;
	end

	logic [9:0] col_q;
	logic [FWW-1:0] fw_q;
	logic [7:0] red_q, green_q, blue_q;
	logic [8:0] alpha_q;
	logic [VW-1:0] dist_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= in_data.column;
			fw_q <= fw_n;
			red_q <= in_data.in_red;
			green_q <= in_data.in_green;
			blue_q <= in_data.in_blue;
			alpha_q <= (in_data.fog_alpha > 9'd256) ? 9'd256 : in_data.fog_alpha;
			dist_q <= (in_data.distance == '0) ? VW'(1) : in_data.distance;
		end
	end

	// span column counter
	logic [FWW-1:0] k_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.load || cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.rd_step || cmd.wr_step) begin
			k_q <= k_q + FWW'(1);
		end
	end

	logic [XW-1:0] addr_x;
	logic [AW-1:0] addr;
	assign addr_x = XW'(col_q) + XW'(k_q);
	assign addr = addr_x[AW-1:0];

	// clear sweep
	logic [AW-1:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_init) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// occlusion buffer
	logic [HW-1:0] mem [SCREEN_WIDTH];
	logic [HW-1:0] rd_data_s1;
	logic [HW-1:0] row_clamp;
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [HW-1:0] mem_wd;

	assign mem_we = cmd.clr_step | cmd.wr_step;
	assign mem_wa = cmd.clr_step ? clr_q : addr;
	assign mem_wd = cmd.clr_step ? HW'(SCREEN_HEIGHT) : row_clamp;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data_s1 <= mem[addr];
	end

	logic rd_vld_s1;
	logic [HW-1:0] lowest_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lowest_q <= '0;
		end else if (rd_vld_s1 && rd_data_s1 > lowest_q) begin
			lowest_q <= rd_data_s1;
		end
	end

	// projection numerator and serial divider
	logic signed [21:0] diff;
	logic signed [32:0] prod;
	logic [DW-1:0] mag;
	assign diff = $signed({2'b00, alt_q}) - $signed({6'b0, in_data.terrain_height, 8'b0});
	assign prod = 33'(diff * $signed({1'b0, scl_q}));
	assign mag = prod[32] ? DW'(-prod) : DW'(prod);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic [VW:0] sh;
	logic take;
	assign sh = {rem_q, quo_q[DW-1]};
	assign take = sh >= {1'b0, dist_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= mag;
			neg_q <= prod[32];
		end else if (cnt_q != '0) begin
			rem_q <= take ? VW'(sh - {1'b0, dist_q}) : sh[VW-1:0];
			quo_q <= {quo_q[DW-2:0], take};
		end
	end

	// row
	logic signed [31:0] qs, ssum, sadj;
	logic signed [RW-1:0] row_q;
	assign qs = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign ssum = qs + 32'(hor_q);
	assign sadj = ssum[31] ? (ssum + 32'sd255) : ssum;

	always_ff @(posedge clk) begin
		if (cmd.row_calc) row_q <= sadj[RW+7:8];
	end

	assign row_clamp = row_q[RW-1] ? '0 : row_q[HW-1:0];

	// output register
	logic out_valid_q;
	vcso_pkg::out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.span_x <= col_q;
			out_q.span_top <= 9'(row_clamp);
			out_q.span_width <= 3'(fw_q);
			out_q.span_height <= 9'(lowest_q - row_clamp);
			out_q.out_red <= vcso_pkg::fog_mix(red_q, sky_r_q, alpha_q);
			out_q.out_green <= vcso_pkg::fog_mix(green_q, sky_g_q, alpha_q);
			out_q.out_blue <= vcso_pkg::fog_mix(blue_q, sky_b_q, alpha_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign sts.in_mode = in_data.mode;
	assign sts.in_col_ok = col_ok;
	assign sts.clr_last = (clr_q == AW'(SCREEN_WIDTH - 1));
	assign sts.k_last = (k_q == fw_q - FWW'(1));
	assign sts.div_busy = (cnt_q != '0);
	assign sts.visible = (lowest_q != '0) &&
		(row_q < $signed({{(RW-HW){1'b0}}, lowest_q}));
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// File: sv/voxel_column_span_occluder.sv
// ----------------------------------------------------------------------------
// voxel_column_span_occluder
// Span stage of a voxel terrain renderer with a per-column occlusion buffer.
// ----------------------------------------------------------------------------
// channel   signals                           transfer when
// in        in_valid / in_ready / in_data     in_valid & in_ready
// out       out_valid / out_ready / out_data  out_valid & out_ready
// cfg       cfg_we / cfg_index / cfg_data     cfg_we
//
// One item at a time. A visible sample steps through read, divide, row, check,
// write and emit; an occluded one returns to idle after the check. The
// projection divider yields one quotient bit per cycle; buffer reads overlap
// the divide, writes take one cycle per covered column. An off-screen sample is dropped in idle.
// A frame start runs a clearing pass over all SCREEN_WIDTH columns; the same pass
// runs after reset, with in_ready low throughout.
// A finished span waits in the output register while the next item is taken;
// a span stalls in its last step until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_column_span_occluder #(
	parameter int SCREEN_WIDTH = 640,
	parameter int SCREEN_HEIGHT = 360,
	parameter int MAX_FILL = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [vcso_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vcso_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire vcso_pkg::in_item_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output vcso_pkg::out_item_t out_data
);

	vcso_pkg::ctl_cmd_t cmd;
	vcso_pkg::ctl_sts_t sts;

	vcso_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	vcso_dpath #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.MAX_FILL(MAX_FILL)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data(out_data),
		.cmd(cmd),
		.sts(sts)
	);

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_step && cmd.wr_step))
		else $error("clear and span write collide");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !in_ready)
		else $error("input taken during clear");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("pending span overwritten");

	a_emit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_step |-> !sts.div_busy)
		else $error("span write before divide done");

endmodule

`default_nettype wire

// File: tb/tb_voxel_column_span_occluder.sv
// ----------------------------------------------------------------------------
// tb_voxel_column_span_occluder
// Self-checking regression of the column span occluder: directed corner
// samples, configuration sweeps and random frames, checked against a local
// projection, occlusion and fog predictor with random sender and receiver gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voxel_column_span_occluder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 640;
	localparam int SH = 360;
	localparam int MAXF = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [vcso_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vcso_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	vcso_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	vcso_pkg::out_item_t out_data;

	voxel_column_span_occluder uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	always #1 clk = ~clk;

	logic [19:0] alt_m;
	logic signed [17:0] hor_m;
	logic [9:0] hsc_m;
	logic [7:0] sky_m [3];
	int unsigned occl [SW];
	vcso_pkg::out_item_t span_q [$];
	int errors = 0;
	int n_items = 0;
	int n_spans = 0;
	int n_frames = 0;
	int burst = 0;

	function automatic logic [7:0] blend(int c, int s, int a);
		return 8'((c * (256 - a) + s * a) >> 8);
	endfunction

	task automatic predict_span(vcso_pkg::in_item_t it);
		int col, fw, dpl, a, lowest;
		longint diff, q, row;
		vcso_pkg::out_item_t o;
		if (!it.mode) begin
			for (int i = 0; i < SW; i++) occl[i] = SH;
			n_frames++;
			return;
		end
		col = it.column;
		if (col >= SW) return;
		fw = it.cover_cols;
		if (fw == 0) fw = 1;
		if (fw > MAXF) fw = MAXF;
		if (col + fw > SW) fw = SW - col;
		dpl = it.distance;
		if (dpl == 0) dpl = 1;
		a = it.fog_alpha;
		if (a > 256) a = 256;
		lowest = occl[col];
		for (int k = 1; k < fw; k++) if (occl[col+k] > lowest) lowest = occl[col+k];
		if (lowest <= 0) return;
		diff = longint'(alt_m) - longint'(it.terrain_height) * 256;
		q = diff * longint'(hsc_m) / dpl;
		row = (q + longint'(hor_m)) / 256;
		if (row >= lowest) return;
		if (row < 0) row = 0;
		for (int k = 0; k < fw; k++) occl[col+k] = int'(row);
		o.span_x = 10'(col);
		o.span_top = 9'(row);
		o.span_width = 3'(fw);
		o.span_height = 9'(lowest - row);
		o.out_red = blend(it.in_red, sky_m[0], a);
		o.out_green = blend(it.in_green, sky_m[1], a);
		o.out_blue = blend(it.in_blue, sky_m[2], a);
		span_q.push_back(o);
	endtask

	// one transfer on the input channel, with burst/gap idling
	task automatic send_item(vcso_pkg::in_item_t it);
		int gap;
		if (burst == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst = $urandom_range(1, 20);
		end
		burst--;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_span(it);
		n_items++;
	endtask

	task automatic drain();
		int guard = 0;
		in_valid <= 1'b0;
		while (span_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (700) @(posedge clk);
	endtask

	task automatic write_reg(logic [vcso_pkg::CFG_IDX_W-1:0] idx,
		logic [vcso_pkg::CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			vcso_pkg::REG_ALTITUDE: alt_m = v;
			vcso_pkg::REG_HORIZON: hor_m = v[17:0];
			vcso_pkg::REG_HSCALE: hsc_m = v[9:0];
			vcso_pkg::REG_SKY_RED: sky_m[0] = v[7:0];
			vcso_pkg::REG_SKY_GREEN: sky_m[1] = v[7:0];
			vcso_pkg::REG_SKY_BLUE: sky_m[2] = v[7:0];
			default: ;
		endcase
	endtask

	task automatic set_view(int alt, int hor, int hsc, int r, int g, int b);
		write_reg(vcso_pkg::REG_ALTITUDE, 20'(alt));
		write_reg(vcso_pkg::REG_HORIZON, 20'(hor));
		write_reg(vcso_pkg::REG_HSCALE, 20'(hsc));
		write_reg(vcso_pkg::REG_SKY_RED, 20'(r));
		write_reg(vcso_pkg::REG_SKY_GREEN, 20'(g));
		write_reg(vcso_pkg::REG_SKY_BLUE, 20'(b));
		cfg_we <= 1'b0;
	endtask

	function automatic vcso_pkg::in_item_t sample(int col, int fw, int dpl, int h, int a);
		vcso_pkg::in_item_t it;
		it.mode = 1'b1;
		it.column = 10'(col);
		it.cover_cols = 3'(fw);
		it.distance = 10'(dpl);
		it.terrain_height = 8'(h);
		it.in_red = 8'($urandom);
		it.in_green = 8'($urandom);
		it.in_blue = 8'($urandom);
		it.fog_alpha = 9'(a);
		return it;
	endfunction

	function automatic vcso_pkg::in_item_t frame_start();
		vcso_pkg::in_item_t it;
		it = vcso_pkg::in_item_t'({1'b0, $urandom, $urandom});
		it.mode = 1'b0;
		return it;
	endfunction

	function automatic vcso_pkg::in_item_t rand_sample();
		vcso_pkg::in_item_t it;
		int r;
		it = vcso_pkg::in_item_t'({1'b0, $urandom, $urandom});
		it.mode = 1'b1;
		r = $urandom_range(0, 99);
		if (r < 90) it.column = 10'($urandom_range(0, SW - 1));
		if (r < 80) it.distance = 10'($urandom_range(1, 200));
		if ($urandom_range(0, 3) != 0) it.fog_alpha = 9'($urandom_range(0, 256));
		return it;
	endfunction

	task automatic test_directed();
		vcso_pkg::in_item_t it;
		send_item(frame_start());
		send_item(sample(0, 1, 1, 0, 0));
		send_item(sample(0, 1, 1, 0, 0));
		send_item(sample(SW - 1, 4, 1023, 255, 256));
		send_item(sample(SW - 2, 7, 0, 128, 511));
		send_item(sample(100, 0, 50, 10, 128));
		send_item(sample(200, 4, 1, 255, 300));
		send_item(sample(700, 4, 10, 0, 0));
		send_item(sample(1023, 7, 10, 0, 0));
		send_item(sample(300, 5, 2, 0, 64));
		send_item(sample(300, 4, 3, 0, 64));
		it = sample(10, 3, 5, 0, 0);
		it.in_red = 8'hff; it.in_green = 8'h00; it.in_blue = 8'hff;
		send_item(it);
		it = sample(20, 2, 1023, 0, 256);
		it.in_red = 8'h00; it.in_green = 8'hff; it.in_blue = 8'h00;
		send_item(it);
		send_item(sample(400, 4, 1, 0, 0));
		send_item(sample(401, 2, 1, 0, 0));
		send_item(sample(402, 1, 600, 200, 100));
		drain();
	endtask

	task automatic test_config_extremes();
		set_view(0, -38400, 1, 0, 0, 0);
		send_item(frame_start());
		for (int i = 0; i < 8; i++) send_item(rand_sample());
		drain();
		set_view(1048575, 130560, 1023, 255, 255, 255);
		send_item(frame_start());
		for (int i = 0; i < 8; i++) send_item(rand_sample());
		drain();
		set_view(131071, -131072, 512, 170, 85, 1);
		for (int i = 0; i < 8; i++) send_item(rand_sample());
		drain();
	endtask

	task automatic test_random_frames(int total);
		while (total > 0) begin
			set_view($urandom_range(0, 1048575), $urandom_range(0, 168960) - 38400,
				$urandom_range(1, 1023), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255));
			send_item(frame_start());
			repeat ($urandom_range(20, 120)) begin
				send_item($urandom_range(0, 60) == 0 ? frame_start() : rand_sample());
				total--;
			end
			drain();
		end
	endtask

	// receiver stall pattern
	int stall_mode = 0;
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin
		vcso_pkg::out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			n_spans++;
			if (span_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected span, expected none, actual %p", $time, out_data);
			end else begin
				e = span_q.pop_front();
				if (e !== out_data) begin
					errors++;
					$display("%0t: span mismatch, expected %p, actual %p", $time, e, out_data);
				end
			end
		end
	end

	initial begin
		alt_m = vcso_pkg::ALTITUDE_RST;
		hor_m = vcso_pkg::HORIZON_RST;
		hsc_m = vcso_pkg::HSCALE_RST;
		sky_m[0] = vcso_pkg::SKY_RED_RST;
		sky_m[1] = vcso_pkg::SKY_GREEN_RST;
		sky_m[2] = vcso_pkg::SKY_BLUE_RST;
		for (int i = 0; i < SW; i++) occl[i] = SH;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_frames(1700);
		if (span_q.size() != 0) begin
			errors++;
			$display("%0t: %0d spans never arrived", $time, span_q.size());
		end
		$display("covered %0d items, %0d spans, %0d frame starts", n_items, n_spans, n_frames);
		if (errors == 0) begin
			$display("voxel_column_span_occluder regression: pass");
		end else begin
			$display("voxel_column_span_occluder regression: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("voxel_column_span_occluder regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
